// ----- hw/rtl/argon2_block_compression_unit_assert.svh -----
// Assertion helpers for the compression unit.
`ifndef ARGON2_BLOCK_COMPRESSION_UNIT_ASSERT_SVH
`define ARGON2_BLOCK_COMPRESSION_UNIT_ASSERT_SVH

// Clocked check, masked during reset.
`define A2BC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check, also active during reset.
`define A2BC_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hw/rtl/a2bc_pkg.sv -----
package a2bc_pkg;

   localparam int WORD_W  = 64;
   localparam int HALF_W  = 32;
   localparam int PAIR_AW = 6;
   localparam int NUM_V   = 16;
   localparam int NUM_PAIRS = 64;

   localparam int ROT_H0 = 32;
   localparam int ROT_H1 = 24;
   localparam int ROT_H2 = 16;
   localparam int ROT_H3 = 63;

   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [PAIR_AW-1:0] pair_addr_type;

   typedef enum logic [10:0] {
      ST_LOAD     = 11'b000_0000_0001,
      ST_READ     = 11'b000_0000_0010,
      ST_MUL      = 11'b000_0000_0100,
      ST_ADD      = 11'b000_0000_1000,
      ST_ROT      = 11'b000_0001_0000,
      ST_DIAG     = 11'b000_0010_0000,
      ST_UNDIAG   = 11'b000_0100_0000,
      ST_WRITE    = 11'b000_1000_0000,
      ST_OUT_RD   = 11'b001_0000_0000,
      ST_OUT_LD   = 11'b010_0000_0000,
      ST_OUT_WAIT = 11'b100_0000_0000
   } state_type;

   typedef struct packed {
      logic          load;
      logic          load_first;
      pair_addr_type rd_addr;
      logic          shift_in;
      logic          src_z;
      logic          mul;
      logic          add;
      logic [1:0]    half;
      logic          rot_col;
      logic          diag;
      logic          undiag;
      logic          z_wr;
      pair_addr_type wr_addr;
      logic          out_load;
   } cmd_type;

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (WORD_W - n));
   endfunction

endpackage

// ----- hw/rtl/a2bc_req_if.sv -----
interface a2bc_req_if;
   import a2bc_pkg::*;
   logic     valid;
   logic     ready;
   word_type left_even;
   word_type left_odd;
   word_type right_even;
   word_type right_odd;
   word_type old_even;
   word_type old_odd;
   logic     accumulate;

   modport source (output valid, left_even, left_odd, right_even, right_odd,
                   old_even, old_odd, accumulate, input ready);
   modport sink   (input valid, left_even, left_odd, right_even, right_odd,
                   old_even, old_odd, accumulate, output ready);
endinterface

// ----- hw/rtl/a2bc_rsp_if.sv -----
interface a2bc_rsp_if;
   import a2bc_pkg::*;
   logic          valid;
   logic          ready;
   word_type      result_even;
   word_type      result_odd;
   pair_addr_type pair_index;
   logic          last_pair;

   modport source (output valid, result_even, result_odd, pair_index, last_pair,
                   input ready);
   modport sink   (input valid, result_even, result_odd, pair_index, last_pair,
                   output ready);
endinterface

// ----- hw/rtl/argon2_block_compression_unit.sv -----
// Argon2 compression G over two 1024-byte blocks.
// req_chan: 64 transactions, each two adjacent words of X, Y and the old
// output block; accumulate is taken from the first transaction of a block.
// One transaction is taken per cycle while loading.
// After the 64th transaction the unit runs sixteen BlaMka permutations
// (eight rows, then eight column groups) on one shared 32x32 multiplier:
// each permutation reads its eight pairs, runs 8 quarter rounds (diagonalizing
// after the fourth, undiagonalizing after the eighth) and writes them back.
// rsp_chan: 64 transactions in pair order, last_pair on index 63; each pair
// is read and registered only after the previous one has been taken.
// req_chan.ready is low from the last input until the last result is taken.
// If the receiver stalls, the current result is held and the unit waits.
// Reset is synchronous: the unit returns to loading with the pair count at
// zero and no result pending; stored words are left as they are.
module argon2_block_compression_unit
   import a2bc_pkg::*;
(
   input logic  clock,
   input logic  reset,
   a2bc_req_if.sink   req_chan,
   a2bc_rsp_if.source rsp_chan
);

   cmd_type cmd;

   a2bc_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   a2bc_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .left_even   (req_chan.left_even),
      .left_odd    (req_chan.left_odd),
      .right_even  (req_chan.right_even),
      .right_odd   (req_chan.right_odd),
      .old_even    (req_chan.old_even),
      .old_odd     (req_chan.old_odd),
      .accumulate  (req_chan.accumulate),
      .result_even (rsp_chan.result_even),
      .result_odd  (rsp_chan.result_odd),
      .pair_index  (rsp_chan.pair_index),
      .last_pair   (rsp_chan.last_pair)
   );

endmodule

// ----- hw/rtl/a2bc_ctl.sv -----
module a2bc_ctl
   import a2bc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   state_type     state_ff, state_in;
   pair_addr_type load_k_ff, load_k_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic [3:0]    perm_ff, perm_in;
   logic [1:0]    quarter_ff, quarter_in;
   logic [1:0]    half_ff, half_in;
   logic          diag_pass_ff, diag_pass_in;
   logic          rsp_valid_ff, rsp_valid_in;
   pair_addr_type perm_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         load_k_ff    <= '0;
         cnt_ff       <= '0;
         perm_ff      <= '0;
         quarter_ff   <= '0;
         half_ff      <= '0;
         diag_pass_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_k_ff    <= load_k_in;
         cnt_ff       <= cnt_in;
         perm_ff      <= perm_in;
         quarter_ff   <= quarter_in;
         half_ff      <= half_in;
         diag_pass_ff <= diag_pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // row pass: pair 8i+j, column pass: pair 8j+i
   assign perm_addr = perm_ff[3] ? {cnt_ff[2:0], perm_ff[2:0]}
                                 : {perm_ff[2:0], cnt_ff[2:0]};

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      load_k_in    = load_k_ff;
      cnt_in       = cnt_ff;
      perm_in      = perm_ff;
      quarter_in   = quarter_ff;
      half_in      = half_ff;
      diag_pass_in = diag_pass_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.half     = half_ff;
      cmd.src_z    = perm_ff[3];
      cmd.rd_addr  = perm_addr;
      cmd.wr_addr  = perm_addr;
      case (state_ff)
         ST_LOAD: begin
            cmd.wr_addr = load_k_ff;
            if (req_valid) begin
               cmd.load       = 1'b1;
               cmd.load_first = (load_k_ff == '0);
               load_k_in      = load_k_ff + 1'b1;
               if (load_k_ff == PAIR_AW'(NUM_PAIRS - 1)) begin
                  state_in = ST_READ;
                  perm_in  = '0;
                  cnt_in   = '0;
               end
            end
         end
         ST_READ: begin
            cmd.shift_in = (cnt_ff != '0);
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == 4'd8) begin
               cnt_in       = '0;
               quarter_in   = '0;
               half_in      = '0;
               diag_pass_in = 1'b0;
               state_in     = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            half_in  = half_ff + 1'b1;
            state_in = (half_ff == 2'd3) ? ST_ROT : ST_MUL;
         end
         ST_ROT: begin
            cmd.rot_col = 1'b1;
            quarter_in  = quarter_ff + 1'b1;
            if (quarter_ff == 2'd3) begin
               if (diag_pass_ff) begin
                  state_in = ST_UNDIAG;
               end else begin
                  diag_pass_in = 1'b1;
                  state_in     = ST_DIAG;
               end
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_DIAG: begin
            cmd.diag = 1'b1;
            state_in = ST_MUL;
         end
         ST_UNDIAG: begin
            cmd.undiag = 1'b1;
            cnt_in     = '0;
            state_in   = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.z_wr = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == 4'd7) begin
               cnt_in  = '0;
               perm_in = perm_ff + 1'b1;
               state_in = (perm_ff == 4'd15) ? ST_OUT_RD : ST_READ;
            end
         end
         ST_OUT_RD: begin
            cmd.rd_addr = load_k_ff;
            state_in    = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            cmd.rd_addr  = load_k_ff;
            cmd.out_load = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               load_k_in    = load_k_ff + 1'b1;
               state_in     = (load_k_ff == PAIR_AW'(NUM_PAIRS - 1)) ? ST_LOAD : ST_OUT_RD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

// ----- hw/rtl/a2bc_dp.sv -----
module a2bc_dp
   import a2bc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   input  word_type      left_even,
   input  word_type      left_odd,
   input  word_type      right_even,
   input  word_type      right_odd,
   input  word_type      old_even,
   input  word_type      old_odd,
   input  logic          accumulate,
   output word_type      result_even,
   output word_type      result_odd,
   output pair_addr_type pair_index,
   output logic          last_pair
);

   logic [2*WORD_W-1:0] work_mem [NUM_PAIRS];
   logic [2*WORD_W-1:0] tail_mem [NUM_PAIRS];
   logic [2*WORD_W-1:0] z_mem    [NUM_PAIRS];
   logic [2*WORD_W-1:0] work_q_ff, tail_q_ff, z_q_ff, pair_q;

   word_type      v_ff [NUM_V];
   word_type      v_in [NUM_V];
   word_type      prod_ff, prod_in;
   word_type      sum;
   logic          acc_ff;
   word_type      res_even_ff, res_odd_ff;
   pair_addr_type idx_ff;
   logic          last_ff;
   word_type      tail_even, tail_odd;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         work_mem[cmd.wr_addr] <= {left_odd ^ right_odd, left_even ^ right_even};
         tail_mem[cmd.wr_addr] <= {old_odd, old_even};
      end
      if (cmd.z_wr) begin
         z_mem[cmd.wr_addr] <= {v_ff[1], v_ff[0]};
      end
      work_q_ff <= work_mem[cmd.rd_addr];
      tail_q_ff <= tail_mem[cmd.rd_addr];
      z_q_ff    <= z_mem[cmd.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= 1'b0;
      end else if (cmd.load && cmd.load_first) begin
         acc_ff <= accumulate;
      end
   end

   assign pair_q = cmd.src_z ? z_q_ff : work_q_ff;

   always_comb begin
      prod_in = prod_ff;
      if (cmd.mul) begin
         if (cmd.half[0]) begin
            prod_in = WORD_W'(v_ff[8][HALF_W-1:0] * v_ff[12][HALF_W-1:0]);
         end else begin
            prod_in = WORD_W'(v_ff[0][HALF_W-1:0] * v_ff[4][HALF_W-1:0]);
         end
      end
   end

   // BlaMka step: x + y + 2*lo(x)*lo(y)
   assign sum = cmd.half[0] ? (v_ff[8] + v_ff[12] + {prod_ff[WORD_W-2:0], 1'b0})
                            : (v_ff[0] + v_ff[4] + {prod_ff[WORD_W-2:0], 1'b0});

   always_comb begin
      word_type mixed;
      for (int m = 0; m < NUM_V; m++) begin
         v_in[m] = v_ff[m];
      end
      mixed = cmd.half[0] ? (v_ff[4] ^ sum) : (v_ff[12] ^ sum);
      if (cmd.shift_in || cmd.z_wr) begin
         for (int m = 0; m < NUM_V - 2; m++) begin
            v_in[m] = v_ff[m+2];
         end
         if (cmd.shift_in) begin
            v_in[NUM_V-2] = pair_q[WORD_W-1:0];
            v_in[NUM_V-1] = pair_q[2*WORD_W-1:WORD_W];
         end
      end
      if (cmd.add) begin
         case (cmd.half)
            2'd0: mixed = rotr(mixed, ROT_H0);
            2'd1: mixed = rotr(mixed, ROT_H1);
            2'd2: mixed = rotr(mixed, ROT_H2);
            2'd3: mixed = rotr(mixed, ROT_H3);
            default: mixed = rotr(mixed, ROT_H0);
         endcase
         if (cmd.half[0]) begin
            v_in[8] = sum;
            v_in[4] = mixed;
         end else begin
            v_in[0]  = sum;
            v_in[12] = mixed;
         end
      end
      if (cmd.rot_col) begin
         for (int r = 0; r < 4; r++) begin
            for (int m = 0; m < 4; m++) begin
               v_in[4*r+m] = v_ff[4*r+((m+1)%4)];
            end
         end
      end
      if (cmd.diag) begin
         for (int r = 0; r < 4; r++) begin
            for (int m = 0; m < 4; m++) begin
               v_in[4*r+m] = v_ff[4*r+((m+r)%4)];
            end
         end
      end
      if (cmd.undiag) begin
         for (int r = 0; r < 4; r++) begin
            for (int m = 0; m < 4; m++) begin
               v_in[4*r+m] = v_ff[4*r+((m+4-r)%4)];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      for (int m = 0; m < NUM_V; m++) begin
         v_ff[m] <= v_in[m];
      end
   end

   assign tail_even = acc_ff ? tail_q_ff[WORD_W-1:0] : '0;
   assign tail_odd  = acc_ff ? tail_q_ff[2*WORD_W-1:WORD_W] : '0;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         res_even_ff <= work_q_ff[WORD_W-1:0] ^ z_q_ff[WORD_W-1:0] ^ tail_even;
         res_odd_ff  <= work_q_ff[2*WORD_W-1:WORD_W] ^ z_q_ff[2*WORD_W-1:WORD_W]
                        ^ tail_odd;
         idx_ff      <= cmd.rd_addr;
         last_ff     <= (cmd.rd_addr == PAIR_AW'(NUM_PAIRS - 1));
      end
   end

   assign result_even = res_even_ff;
   assign result_odd  = res_odd_ff;
   assign pair_index  = idx_ff;
   assign last_pair   = last_ff;

endmodule

// ----- hw/rtl/a2bc_checker.sv -----
`include "argon2_block_compression_unit_assert.svh"

module a2bc_checker
   import a2bc_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          req_ready,
   input logic          rsp_valid,
   input logic          rsp_ready,
   input pair_addr_type rsp_pair_index,
   input logic          rsp_last_pair
);

   `A2BC_ASSERT_RST(a_reset_idle, reset |=> !rsp_valid, "result valid after reset")
   `A2BC_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "stalled result dropped")
   `A2BC_ASSERT(a_no_overlap, rsp_valid |-> !req_ready, "input taken while result pending")
   `A2BC_ASSERT(a_last_idx, rsp_valid |-> (rsp_last_pair == (rsp_pair_index == 6'd63)), "last flag mismatch")
   `A2BC_ASSERT(a_gap, rsp_valid && rsp_ready |=> !rsp_valid, "result repeated")

endmodule

bind argon2_block_compression_unit a2bc_checker u_a2bc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_pair_index (rsp_chan.pair_index),
   .rsp_last_pair  (rsp_chan.last_pair)
);

// ----- test/compression_checker.sv -----
module compression_checker
   import a2bc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   a2bc_req_if  req_mon,
   a2bc_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_count,
   output int   block_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      word_type      even_w;
      word_type      odd_w;
      pair_addr_type index;
      logic          last;
   } pair_type;

   word_type   xy_words[128];
   word_type   prior_words[128];
   int unsigned pair_count;
   logic        mode_acc;
   pair_type    expected_pairs[$];

   function automatic word_type ror64(word_type v, int n);
      return (v >> n) | (v << (64 - n));
   endfunction

   function automatic word_type blamka(word_type p, word_type q);
      word_type lo;
      lo = {32'b0, p[31:0]} * {32'b0, q[31:0]};
      return p + q + (lo << 1);
   endfunction

   task automatic mix_quarter(inout word_type v[16], input int a, b, c, d);
      v[a] = blamka(v[a], v[b]);
      v[d] = ror64(v[d] ^ v[a], 32);
      v[c] = blamka(v[c], v[d]);
      v[b] = ror64(v[b] ^ v[c], 24);
      v[a] = blamka(v[a], v[b]);
      v[d] = ror64(v[d] ^ v[a], 16);
      v[c] = blamka(v[c], v[d]);
      v[b] = ror64(v[b] ^ v[c], 63);
   endtask

   task automatic permute16(inout word_type v[16]);
      mix_quarter(v, 0, 4, 8, 12);
      mix_quarter(v, 1, 5, 9, 13);
      mix_quarter(v, 2, 6, 10, 14);
      mix_quarter(v, 3, 7, 11, 15);
      mix_quarter(v, 0, 5, 10, 15);
      mix_quarter(v, 1, 6, 11, 12);
      mix_quarter(v, 2, 7, 8, 13);
      mix_quarter(v, 3, 4, 9, 14);
   endtask

   task automatic compress_block();
      word_type z[128];
      word_type v[16];
      pair_type p;
      for (int w = 0; w < 128; w++) z[w] = xy_words[w];
      for (int r = 0; r < 8; r++) begin
         for (int j = 0; j < 16; j++) v[j] = z[16*r + j];
         permute16(v);
         for (int j = 0; j < 16; j++) z[16*r + j] = v[j];
      end
      for (int c = 0; c < 8; c++) begin
         for (int j = 0; j < 8; j++) begin
            v[2*j]   = z[16*j + 2*c];
            v[2*j+1] = z[16*j + 2*c + 1];
         end
         permute16(v);
         for (int j = 0; j < 8; j++) begin
            z[16*j + 2*c]     = v[2*j];
            z[16*j + 2*c + 1] = v[2*j+1];
         end
      end
      for (int k = 0; k < 64; k++) begin
         p.even_w = xy_words[2*k] ^ z[2*k];
         p.odd_w  = xy_words[2*k+1] ^ z[2*k+1];
         if (mode_acc) begin
            p.even_w ^= prior_words[2*k];
            p.odd_w  ^= prior_words[2*k+1];
         end
         p.index = pair_addr_type'(k);
         p.last  = (k == 63);
         expected_pairs.push_back(p);
      end
   endtask

   assign pending_count = expected_pairs.size();

   always @(posedge clock) begin
      pair_type e;
      if (reset) begin
         pair_count = 0;
         mode_acc   = 0;
         fail_count = 0;
         block_count = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            if (pair_count == 0) mode_acc = req_mon.accumulate;
            xy_words[2*pair_count]      = req_mon.left_even ^ req_mon.right_even;
            xy_words[2*pair_count+1]    = req_mon.left_odd ^ req_mon.right_odd;
            prior_words[2*pair_count]   = req_mon.old_even;
            prior_words[2*pair_count+1] = req_mon.old_odd;
            if (pair_count == 63) begin
               pair_count = 0;
               compress_block();
            end else begin
               pair_count++;
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_pairs.size() == 0) begin
               $display("%0t unexpected transaction index %0d", $time,
                        rsp_mon.pair_index);
               fail_count++;
            end else begin
               e = expected_pairs.pop_front();
               if (rsp_mon.result_even !== e.even_w || rsp_mon.result_odd !== e.odd_w
                   || rsp_mon.pair_index !== e.index || rsp_mon.last_pair !== e.last) begin
                  $display("%0t mismatch exp %h %h %0d %b got %h %h %0d %b", $time,
                           e.even_w, e.odd_w, e.index, e.last, rsp_mon.result_even,
                           rsp_mon.result_odd, rsp_mon.pair_index, rsp_mon.last_pair);
                  fail_count++;
               end
               if (e.last) block_count++;
            end
         end
      end
   end
endmodule

// ----- test/tb_top.sv -----
module tb_top;
   import a2bc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 0;
   logic reset = 1;
   int   fail_count, pending_count, block_count;
   longint cycle_count = 0;
   int   rsp_wait = 0;
   bit   rsp_taken = 0;

   a2bc_req_if req_chan();
   a2bc_rsp_if rsp_chan();

   argon2_block_compression_unit uut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   compression_checker chk (
      .clock(clock), .reset(reset), .req_mon(req_chan), .rsp_mon(rsp_chan),
      .fail_count(fail_count), .pending_count(pending_count),
      .block_count(block_count)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 40000) begin
         $display("timeout at cycle %0d", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic word_type rand_word(int style);
      case (style)
         0: return '0;
         1: return '1;
         2: return 64'h1 << $urandom_range(0, 63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic send_pair(int style, logic acc);
      int gap;
      gap = $urandom_range(0, 14);
      @(negedge clock);
      if (gap != 0) begin
         req_chan.valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid      <= 1;
      req_chan.left_even  <= rand_word(style);
      req_chan.left_odd   <= rand_word(style);
      req_chan.right_even <= rand_word(style == 1 ? 0 : 3);
      req_chan.right_odd  <= rand_word(3);
      req_chan.old_even   <= rand_word(3);
      req_chan.old_odd    <= rand_word(3);
      req_chan.accumulate <= acc;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_block(int style, int acc_first);
      for (int k = 0; k < 64; k++) begin
         send_pair(style < 0 ? int'($urandom_range(0, 3)) : style,
                   k == 0 ? logic'(acc_first) : logic'($urandom_range(0, 1)));
      end
   endtask

   always @(posedge clock) begin
      rsp_taken <= rsp_chan.valid && rsp_chan.ready;
   end

   // per-transaction wait, counted while a result is offered
   always @(negedge clock) begin
      if (reset) begin
         rsp_wait = $urandom_range(0, 14);
         rsp_chan.ready <= 0;
      end else begin
         if (rsp_taken) rsp_wait = $urandom_range(0, 14);
         if (rsp_wait != 0) begin
            if (rsp_chan.valid) rsp_wait--;
            rsp_chan.ready <= 0;
         end else begin
            rsp_chan.ready <= 1;
         end
      end
   end

   initial begin
      req_chan.valid = 0;
      req_chan.left_even = 0; req_chan.left_odd = 0;
      req_chan.right_even = 0; req_chan.right_odd = 0;
      req_chan.old_even = 0; req_chan.old_odd = 0;
      req_chan.accumulate = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // mixed zero/ones/single-bit/random words, then a random block
      send_block(-1, 1);
      send_block(3, 0);
      // trailing partial block of noise
      for (int k = 0; k < 2; k++) send_pair(3, $urandom_range(0, 1));
      @(negedge clock);
      req_chan.valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (2000) @(posedge clock);
      $display("covered %0d compressed blocks of mixed zero/ones/single-bit/random words",
               block_count);
      $display("both overwrite and accumulate modes, random stalls on both sides");
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
